// ===== rtl/montgomery_prime_field_alu_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the prime-field ALU
// Shared concurrent-assertion forms; clk and rst are taken from the using scope.
// ----------------------------------------------------------------------------
`ifndef MONTGOMERY_PRIME_FIELD_ALU_CORE_ASSERT_SVH
`define MONTGOMERY_PRIME_FIELD_ALU_CORE_ASSERT_SVH

// same-cycle implication
`define MPF_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// next-cycle implication
`define MPF_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

// ===== rtl/mpf_pkg.sv =====
// ----------------------------------------------------------------------------
// mpf_pkg
// Opcodes, register indexes and pipeline constants of the prime-field ALU.
// ----------------------------------------------------------------------------
package mpf_pkg;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_DBL   = 3'd2,
    OP_HALVE = 3'd3,
    OP_NEG   = 3'd4,
    OP_MUL   = 3'd5
  } op_t;

  localparam int ROUND_STAGES  = 8;   // register stages of one Montgomery round
  localparam int ADDSUB_STAGES = 2;
  localparam int APB_AW        = 6;
  localparam logic [2:0] REG_NINV = 3'd4;

endpackage

// ===== rtl/mpf_lane.sv =====
// ----------------------------------------------------------------------------
// mpf_lane
// One limb multiplier lane: half-width partial products, then their sum.
// Two register stages, advanced by en.
// ----------------------------------------------------------------------------
module mpf_lane #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   x,
  input  logic [W-1:0]   y,
  output logic [2*W-1:0] prod
);
  localparam int H = (W + 1) / 2;
  localparam int G = W - H;

  logic [2*H-1:0] ll;
  logic [H+G-1:0] lh;
  logic [H+G-1:0] hl;
  logic [2*G-1:0] hh;

  always_ff @(posedge clk) begin
    if (en) begin
      ll   <= x[H-1:0] * y[H-1:0];
      lh   <= x[H-1:0] * y[W-1:H];
      hl   <= x[W-1:H] * y[H-1:0];
      hh   <= x[W-1:H] * y[W-1:H];
      prod <= (2*W)'(ll) + ((2*W)'(lh) << H) + ((2*W)'(hl) << H)
            + ((2*W)'(hh) << (2*H));
    end
  end
endmodule

// ===== rtl/mpf_round.sv =====
// ----------------------------------------------------------------------------
// mpf_round
// One interleaved Montgomery round: z = (z + a_i*b + m*p) / 2^W with
// m = t*ninv mod 2^W. Limb products run in parallel lanes.
// ----------------------------------------------------------------------------
module mpf_round #(
  parameter int LIMBS = 4,
  parameter int W     = 64,
  parameter int IDX   = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [LIMBS*W-1:0]   a_in,
  input  logic [LIMBS*W-1:0]   b_in,
  input  logic [LIMBS*W:0]     z_in,
  input  logic [LIMBS*W-1:0]   p,
  input  logic [W-1:0]         ninv,
  output logic [LIMBS*W-1:0]   a_out,
  output logic [LIMBS*W-1:0]   b_out,
  output logic [LIMBS*W:0]     z_out
);
  import mpf_pkg::*;

  localparam int N  = LIMBS * W;
  localparam int TW = N + W + 1;

  logic [N-1:0]   a_d [ROUND_STAGES];
  logic [N-1:0]   b_d [ROUND_STAGES];
  logic [N:0]     z1, z2;
  logic [TW-1:0]  t3, t4, t5, t6, t7;
  logic [2*W-1:0] pa [LIMBS];
  logic [2*W-1:0] pq [LIMBS];
  logic [2*W-1:0] mprod;
  logic [N-1:0]   alo, ahi, qlo, qhi;
  logic [TW-1:0]  qsum;

  genvar j;
  generate
    for (j = 0; j < LIMBS; j++) begin : g_lane
      mpf_lane #(.W(W)) u_ab (
        .clk(clk), .en(en), .x(a_in[IDX*W +: W]), .y(b_in[j*W +: W]), .prod(pa[j])
      );
      mpf_lane #(.W(W)) u_mp (
        .clk(clk), .en(en), .x(mprod[W-1:0]), .y(p[j*W +: W]), .prod(pq[j])
      );
      assign alo[j*W +: W] = pa[j][W-1:0];
      assign ahi[j*W +: W] = pa[j][2*W-1:W];
      assign qlo[j*W +: W] = pq[j][W-1:0];
      assign qhi[j*W +: W] = pq[j][2*W-1:W];
    end
  endgenerate

  mpf_lane #(.W(W)) u_m (
    .clk(clk), .en(en), .x(t3[W-1:0]), .y(ninv), .prod(mprod)
  );

  assign qsum = t7 + TW'(qlo) + (TW'(qhi) << W);

  always_ff @(posedge clk) begin
    if (en) begin
      a_d[0] <= a_in;
      b_d[0] <= b_in;
      for (int k = 1; k < ROUND_STAGES; k++) begin
        a_d[k] <= a_d[k-1];
        b_d[k] <= b_d[k-1];
      end
      z1    <= z_in;
      z2    <= z1;
      t3    <= TW'(z2) + TW'(alo) + (TW'(ahi) << W);
      t4    <= t3;
      t5    <= t4;
      t6    <= t5;
      t7    <= t6;
      z_out <= qsum[TW-1:W];
    end
  end

  assign a_out = a_d[ROUND_STAGES-1];
  assign b_out = b_d[ROUND_STAGES-1];
endmodule

// ===== rtl/mpf_addsub.sv =====
// ----------------------------------------------------------------------------
// mpf_addsub
// Add, subtract, double, halve and negate modulo p in two stages:
// raw sum or difference first, then the modulus correction.
// ----------------------------------------------------------------------------
module mpf_addsub #(
  parameter int N = 256
) (
  input  logic          clk,
  input  logic          en,
  input  mpf_pkg::op_t  op,
  input  logic [N-1:0]  a,
  input  logic [N-1:0]  b,
  input  logic [N-1:0]  p,
  output logic [N-1:0]  res
);
  import mpf_pkg::*;

  op_t          op1;
  logic [N:0]   s1;
  logic [N:0]   s_next;
  logic [N+1:0] dp;
  logic [N-1:0] r_next;

  always_comb begin
    unique case (op)
      OP_ADD:   s_next = (N+1)'(a) + (N+1)'(b);
      OP_DBL:   s_next = (N+1)'(a) + (N+1)'(a);
      OP_SUB:   s_next = (N+1)'(a) - (N+1)'(b);   // top bit is the borrow
      OP_HALVE: s_next = a[0] ? (N+1)'(a) + (N+1)'(p) : (N+1)'(a);
      OP_NEG:   s_next = {|a, p - a};             // top bit marks nonzero a
      default:  s_next = '0;
    endcase
  end

  assign dp = (N+2)'(s1) - (N+2)'(p);

  always_comb begin
    unique case (op1)
      OP_ADD, OP_DBL: r_next = dp[N+1] ? s1[N-1:0] : dp[N-1:0];
      OP_SUB:         r_next = s1[N] ? s1[N-1:0] + p : s1[N-1:0];
      OP_HALVE:       r_next = s1[N:1];
      OP_NEG:         r_next = s1[N] ? s1[N-1:0] : '0;
      default:        r_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= op;
      s1  <= s_next;
      res <= r_next;
    end
  end
endmodule

// ===== rtl/montgomery_prime_field_alu_core.sv =====
// ----------------------------------------------------------------------------
// montgomery_prime_field_alu_core
// Prime-field ALU over Montgomery-form elements, one item per cycle.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the opcode, s_tdata operands a and b. Output
// stream: m_tdata the reduced result, m_tuser the zero flag.
// Modulus limbs and the negated inverse are written over the APB port at
// byte address 8*i (limbs 0..LIMBS-1, then neg_inverse at 32); write them
// only while no item is in flight.
// Every opcode goes through the same number of register stages: each
// Montgomery round takes eight register stages (two-stage split limb
// multipliers for a_i*b, for m and for m*p, plus two accumulate adds), and
// one last stage does the final subtract and picks the result. Non-multiply
// ops finish in two stages and ride a delay line to the same point.
// Throughput is one item per cycle. If the receiver stalls, the result holds
// in the output register; the pipeline keeps moving while its last stage
// is empty; s_tready drops only once an item waits behind the held result.
// Synchronous reset clears the configuration registers and every valid flag.
// ----------------------------------------------------------------------------
`include "montgomery_prime_field_alu_core_assert.svh"

module montgomery_prime_field_alu_core #(
  parameter int LIMBS     = 4,
  parameter int LIMB_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: operand_a_limb_0..LIMBS-1, operand_b_limb_0..LIMBS-1, zero pad
  input  logic [((2*LIMBS*LIMB_BITS+7)/8)*8-1:0] s_tdata,
  // s_tuser: operation
  input  logic [2:0]                     s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // m_tdata: result_limb_0..LIMBS-1, zero pad
  output logic [((LIMBS*LIMB_BITS+7)/8)*8-1:0]   m_tdata,
  // m_tuser: result_is_zero
  output logic [0:0]                     m_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpf_pkg::APB_AW-1:0]     paddr,
  input  logic [63:0]                    pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready
);
  import mpf_pkg::*;

  localparam int W   = LIMB_BITS;
  localparam int N   = LIMBS * W;
  localparam int D   = ROUND_STAGES * LIMBS;
  localparam int RD  = D - ADDSUB_STAGES;
  localparam int ODW = ((N + 7) / 8) * 8;

  // configuration
  logic [W-1:0] mod_reg [LIMBS];
  logic [W-1:0] ninv;
  logic [N-1:0] p_flat;
  logic [2:0]   idx;
  logic         wr;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LIMBS; k++) mod_reg[k] <= '0;
      ninv <= '0;
    end else if (wr) begin
      for (int k = 0; k < LIMBS; k++) begin
        if (idx == 3'(k)) mod_reg[k] <= pwdata[W-1:0];
      end
      if (idx == REG_NINV) ninv <= pwdata[W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    for (int k = 0; k < LIMBS; k++) begin
      if (idx == 3'(k)) prdata = 64'(mod_reg[k]);
    end
    if (idx == REG_NINV) prdata = 64'(ninv);
  end

  genvar g;
  generate
    for (g = 0; g < LIMBS; g++) begin : g_mod
      assign p_flat[g*W +: W] = mod_reg[g];
    end
  endgenerate

  // pipeline control
  logic         adv;
  logic [D-1:0] v;
  op_t          op_d [D];
  logic [N-1:0] res_d [RD];
  logic [N-1:0] as_res;
  logic         out_valid;
  op_t          op_in;

  assign op_in    = op_t'(s_tuser);
  assign adv      = !v[D-1] || !out_valid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[D-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_d[0] <= op_in;
      for (int k = 1; k < D; k++) op_d[k] <= op_d[k-1];
      res_d[0] <= as_res;
      for (int k = 1; k < RD; k++) res_d[k] <= res_d[k-1];
    end
  end

  mpf_addsub #(.N(N)) u_addsub (
    .clk(clk), .en(adv), .op(op_in),
    .a(s_tdata[N-1:0]), .b(s_tdata[2*N-1:N]), .p(p_flat), .res(as_res)
  );

  // Montgomery rounds
  logic [N-1:0] a_c [LIMBS+1];
  logic [N-1:0] b_c [LIMBS+1];
  logic [N:0]   z_c [LIMBS+1];

  assign a_c[0] = s_tdata[N-1:0];
  assign b_c[0] = s_tdata[2*N-1:N];
  assign z_c[0] = '0;

  generate
    for (g = 0; g < LIMBS; g++) begin : g_round
      mpf_round #(.LIMBS(LIMBS), .W(W), .IDX(g)) u_round (
        .clk(clk), .en(adv),
        .a_in(a_c[g]), .b_in(b_c[g]), .z_in(z_c[g]),
        .p(p_flat), .ninv(ninv),
        .a_out(a_c[g+1]), .b_out(b_c[g+1]), .z_out(z_c[g+1])
      );
    end
  endgenerate

  // merge: final subtract for multiply, pick result, zero flag
  logic [N+1:0] zd;
  logic [N-1:0] mul_res;
  logic [N-1:0] sel_res;
  logic [N-1:0] out_res;
  logic         out_zero;

  assign zd      = (N+2)'(z_c[LIMBS]) - (N+2)'(p_flat);
  assign mul_res = zd[N+1] ? z_c[LIMBS][N-1:0] : zd[N-1:0];
  assign sel_res = (op_d[D-1] == OP_MUL) ? mul_res : res_d[RD-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && v[D-1]) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v[D-1]) begin
      out_res  <= sel_res;
      out_zero <= ~|sel_res;
    end
  end

  assign m_tdata  = ODW'(out_res);
  assign m_tuser  = out_zero;
  assign m_tvalid = out_valid;

  `MPF_ASSERT_IMP(a_bubble_ready, !v[D-1], s_tready, "pipeline not ready with empty tail")
  `MPF_ASSERT_NXT(a_stall_hold, v[D-1] && out_valid && !m_tready, $stable(v),
                  "pipeline moved while blocked")
  `MPF_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, v[0], "accepted item lost")
endmodule
